/* rtl/core/impd_pkg.sv */
// Shared types, constants and a helper function of the interrupt dispatch unit.
package impd_pkg;

    // Command codes
    typedef enum logic [1:0] {
        CMD_MASK     = 2'd0,
        CMD_UNMASK   = 2'd1,
        CMD_DISPATCH = 2'd2
    } t_cmd;

    // Interrupt word bits owned by each device group
    localparam logic [31:0] GRP_MI   = 32'hF800_0000;
    localparam logic [31:0] GRP_DSP  = 32'h0700_0000;
    localparam logic [31:0] GRP_AI   = 32'h0080_0000;
    localparam logic [31:0] GRP_EXI0 = 32'h0070_0000;
    localparam logic [31:0] GRP_EXI1 = 32'h000E_0000;
    localparam logic [31:0] GRP_EXI2 = 32'h0001_8000;
    localparam logic [31:0] GRP_PI   = 32'h0000_7FF0;

    localparam logic [14:0] PI_FIXED   = 15'h00F0;
    localparam logic [31:0] MASK_RESET = 32'hFFFF_FFF0;

    // Fixed dispatch priority, first entry wins
    localparam int PRIO_DEPTH = 12;
    localparam logic [31:0] PRIO_TABLE [0:PRIO_DEPTH-1] = '{
        32'h0000_0100, 32'h0000_0040, 32'hF800_0000, 32'h0000_0200,
        32'h0000_0080, 32'h0000_0010, 32'h0000_3000, 32'h0000_0020,
        32'h03FF_8C00, 32'h0400_0000, 32'h0000_4000, 32'hFFFF_FFFF
    };

    // Device enable images
    typedef struct packed {
        logic [4:0]  mi;
        logic [8:0]  dsp;
        logic [2:0]  ai;
        logic [10:0] exi0;
        logic [10:0] exi1;
        logic [2:0]  exi2;
        logic [14:0] pi;
    } t_en;

    localparam t_en EN_RESET = '{
        mi: 5'd0, dsp: 9'd0, ai: 3'd0, exi0: 11'd0, exi1: 11'd0, exi2: 3'd0,
        pi: PI_FIXED
    };

    // Dispatch outcome
    typedef struct packed {
        logic       found;
        logic [4:0] number;
    } t_irq;

    // Leading-zero count of a 32-bit word, zero for an all-zero word
    function automatic logic [4:0] lzc32(input logic [31:0] v);
        logic [4:0] res;
        res = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) begin
                res = 5'(31 - i);
            end
        end
        return res;
    endfunction

endpackage

/* rtl/core/impd_mask_upd.sv */
// Masked set and device enable registers with their mask and unmask update.
module impd_mask_upd (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  logic [1:0]         i_cmd,
    input  logic [31:0]        i_user_mask,
    input  logic [31:0]        i_cur_mask,
    output logic [31:0]        o_masked_set,
    output impd_pkg::t_en      o_en,
    output impd_pkg::t_en      o_en_next
);
    import impd_pkg::*;

    logic [31:0] r_masked_set;
    logic [31:0] n_masked_set;
    t_en         r_en;
    t_en         n_en;
    logic [31:0] eff_old;
    logic [31:0] touched;
    logic [31:0] open_bits;

    // Work out the new masked set and the groups whose state moves
    always_comb begin
        eff_old = r_masked_set | i_cur_mask;
        case (i_cmd)
            CMD_MASK: begin
                touched      = i_user_mask & ~eff_old;
                n_masked_set = r_masked_set | i_user_mask;
            end
            CMD_UNMASK: begin
                touched      = i_user_mask & eff_old;
                n_masked_set = r_masked_set & ~i_user_mask;
            end
            default: begin
                touched      = 32'd0;
                n_masked_set = r_masked_set;
            end
        endcase
        open_bits = ~(n_masked_set | i_cur_mask);
    end

    // Rebuild the enable image of every touched group
    always_comb begin
        n_en = r_en;
        if ((touched & GRP_MI) != 32'd0) begin
            n_en.mi = {open_bits[27], open_bits[28], open_bits[29],
                       open_bits[30], open_bits[31]};
        end
        if ((touched & GRP_DSP) != 32'd0) begin
            n_en.dsp    = 9'd0;
            n_en.dsp[4] = open_bits[26];
            n_en.dsp[6] = open_bits[25];
            n_en.dsp[8] = open_bits[24];
        end
        if ((touched & GRP_AI) != 32'd0) begin
            n_en.ai    = 3'd0;
            n_en.ai[2] = open_bits[23];
        end
        if ((touched & GRP_EXI0) != 32'd0) begin
            n_en.exi0     = 11'd0;
            n_en.exi0[0]  = open_bits[22];
            n_en.exi0[2]  = open_bits[21];
            n_en.exi0[10] = open_bits[20];
        end
        if ((touched & GRP_EXI1) != 32'd0) begin
            n_en.exi1     = 11'd0;
            n_en.exi1[0]  = open_bits[19];
            n_en.exi1[2]  = open_bits[18];
            n_en.exi1[10] = open_bits[17];
        end
        if ((touched & GRP_EXI2) != 32'd0) begin
            n_en.exi2    = 3'd0;
            n_en.exi2[0] = open_bits[16];
            n_en.exi2[2] = open_bits[15];
        end
        if ((touched & GRP_PI) != 32'd0) begin
            n_en.pi     = PI_FIXED;
            n_en.pi[11] = open_bits[14];
            n_en.pi[3]  = open_bits[11];
            n_en.pi[2]  = open_bits[10];
            n_en.pi[1]  = open_bits[9];
            n_en.pi[0]  = open_bits[8];
            n_en.pi[8]  = open_bits[7];
            n_en.pi[12] = open_bits[6];
            n_en.pi[9]  = open_bits[13];
            n_en.pi[10] = open_bits[12];
            n_en.pi[13] = open_bits[5];
            n_en.pi[14] = open_bits[4];
        end
    end

    // Commit the state as the transaction moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_masked_set <= MASK_RESET;
            r_en         <= EN_RESET;
        end else if (i_advance) begin
            r_masked_set <= n_masked_set;
            r_en         <= n_en;
        end
    end

    assign o_masked_set = r_masked_set;
    assign o_en         = r_en;
    assign o_en_next    = n_en;

endmodule

/* rtl/core/impd_dispatch.sv */
// Cause gathering and fixed-priority selection for a dispatch command.
module impd_dispatch (
    input  logic               i_enable,
    input  logic [16:0]        i_pi_cause,
    input  logic [4:0]         i_mi_status,
    input  logic [8:0]         i_dsp_status,
    input  logic [3:0]         i_ai_status,
    input  logic [11:0]        i_exi0_status,
    input  logic [11:0]        i_exi1_status,
    input  logic [3:0]         i_exi2_status,
    input  logic [14:0]        i_pi_en,
    input  logic [31:0]        i_eff_mask,
    output impd_pkg::t_irq     o_irq
);
    import impd_pkg::*;

    logic [15:0] intsr;
    logic        pending;
    logic [31:0] cause;
    logic [31:0] live;
    logic [31:0] sel;
    logic        hit_any;

    // Gather cause bits from the processor interface and device status
    always_comb begin
        intsr   = i_pi_cause[15:0];
        pending = (intsr != 16'd0) && ((intsr & {1'b0, i_pi_en}) != 16'd0);
        cause   = 32'd0;
        if (intsr[7]) begin
            cause[31] = i_mi_status[0];
            cause[30] = i_mi_status[1];
            cause[29] = i_mi_status[2];
            cause[28] = i_mi_status[3];
            cause[27] = i_mi_status[4];
        end
        if (intsr[6]) begin
            cause[26] = i_dsp_status[3];
            cause[25] = i_dsp_status[5];
            cause[24] = i_dsp_status[7];
        end
        if (intsr[5]) begin
            cause[23] = i_ai_status[3];
        end
        if (intsr[4]) begin
            cause[22] = i_exi0_status[1];
            cause[21] = i_exi0_status[3];
            cause[20] = i_exi0_status[11];
            cause[19] = i_exi1_status[1];
            cause[18] = i_exi1_status[3];
            cause[17] = i_exi1_status[11];
            cause[16] = i_exi2_status[1];
            cause[15] = i_exi2_status[3];
        end
        cause[5]  = cause[5]  | intsr[13];
        cause[6]  = cause[6]  | intsr[12];
        cause[12] = cause[12] | intsr[10];
        cause[13] = cause[13] | intsr[9];
        cause[7]  = cause[7]  | intsr[8];
        cause[11] = cause[11] | intsr[3];
        cause[10] = cause[10] | intsr[2];
        cause[9]  = cause[9]  | intsr[1];
        cause[14] = cause[14] | intsr[11];
        cause[8]  = cause[8]  | intsr[0];
        cause[4]  = cause[4]  | intsr[14];
        live = cause & ~i_eff_mask;
    end

    // Take the first priority entry that hits
    always_comb begin
        sel     = 32'd0;
        hit_any = 1'b0;
        for (int i = 0; i < PRIO_DEPTH; i++) begin
            if (!hit_any && ((live & PRIO_TABLE[i]) != 32'd0)) begin
                sel     = live & PRIO_TABLE[i];
                hit_any = 1'b1;
            end
        end
        o_irq.found  = i_enable && pending && hit_any;
        o_irq.number = o_irq.found ? lzc32(sel) : 5'd0;
    end

endmodule

/* rtl/core/interrupt_mask_and_priority_dispatch_unit.sv */
// Interrupt mask and priority dispatch unit, top level.
// Each transaction is one command: mask (0) or unmask (1) bits of the
// 32-bit logical interrupt word (interrupt n is bit 31-n), or dispatch (2)
// the highest-priority unmasked pending interrupt from the device status
// fields. Every command yields exactly one result with the masked set
// before the command and the device enable images after it. A command is
// taken into an input register, evaluated by combinational remap and
// priority logic, and lands in a result register once that is free,
// raising o_valid; one command per cycle is sustained while i_stall is
// low. A stalled result holds the input register, and o_stall is raised
// only while both registers are full and i_stall is high. The user must
// write the current_mask register through i_cfg_wr_en/i_cfg_wr_data
// only while no command is in flight; the block does not enforce it.
module interrupt_mask_and_priority_dispatch_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_user_mask,
    input  logic [16:0] i_pi_cause,
    input  logic [4:0]  i_mi_status,
    input  logic [8:0]  i_dsp_status,
    input  logic [3:0]  i_ai_status,
    input  logic [11:0] i_exi0_status,
    input  logic [11:0] i_exi1_status,
    input  logic [3:0]  i_exi2_status,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_old_masked_set,
    output logic [4:0]  o_mi_enable,
    output logic [8:0]  o_dsp_enable,
    output logic [2:0]  o_ai_enable,
    output logic [10:0] o_exi0_enable,
    output logic [10:0] o_exi1_enable,
    output logic [2:0]  o_exi2_enable,
    output logic [14:0] o_pi_enable,
    output logic        o_irq_found,
    output logic [4:0]  o_irq_number
);
    import impd_pkg::*;

    logic [31:0] r_cur_mask;
    logic        r_in_valid;
    logic [1:0]  r_in_cmd;
    logic [31:0] r_in_user_mask;
    logic [16:0] r_in_pi_cause;
    logic [4:0]  r_in_mi_status;
    logic [8:0]  r_in_dsp_status;
    logic [3:0]  r_in_ai_status;
    logic [11:0] r_in_exi0_status;
    logic [11:0] r_in_exi1_status;
    logic [3:0]  r_in_exi2_status;
    logic        r_out_valid;
    logic [31:0] r_out_old;
    t_en         r_out_en;
    t_irq        r_out_irq;

    logic        out_free;
    logic        advance;
    logic        in_accept;
    logic [31:0] masked_set;
    t_en         en_cur;
    t_en         en_next;
    t_irq        irq;

    // Handshake: the result register frees when empty or taken
    assign out_free  = !r_out_valid || !i_stall;
    assign advance   = r_in_valid && out_free;
    assign o_stall   = r_in_valid && !out_free;
    assign in_accept = i_valid && !o_stall;

    // Hold the context mask register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_mask <= 32'd0;
        end else if (i_cfg_wr_en) begin
            r_cur_mask <= i_cfg_wr_data;
        end
    end

    // Capture the accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_accept || (r_in_valid && !advance);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_cmd         <= i_cmd;
            r_in_user_mask   <= i_user_mask;
            r_in_pi_cause    <= i_pi_cause;
            r_in_mi_status   <= i_mi_status;
            r_in_dsp_status  <= i_dsp_status;
            r_in_ai_status   <= i_ai_status;
            r_in_exi0_status <= i_exi0_status;
            r_in_exi1_status <= i_exi1_status;
            r_in_exi2_status <= i_exi2_status;
        end
    end

    impd_mask_upd u_mask_upd (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_cmd        (r_in_cmd),
        .i_user_mask  (r_in_user_mask),
        .i_cur_mask   (r_cur_mask),
        .o_masked_set (masked_set),
        .o_en         (en_cur),
        .o_en_next    (en_next)
    );

    impd_dispatch u_dispatch (
        .i_enable      (r_in_cmd == CMD_DISPATCH),
        .i_pi_cause    (r_in_pi_cause),
        .i_mi_status   (r_in_mi_status),
        .i_dsp_status  (r_in_dsp_status),
        .i_ai_status   (r_in_ai_status),
        .i_exi0_status (r_in_exi0_status),
        .i_exi1_status (r_in_exi1_status),
        .i_exi2_status (r_in_exi2_status),
        .i_pi_en       (en_cur.pi),
        .i_eff_mask    (masked_set | r_cur_mask),
        .o_irq         (irq)
    );

    // Advance the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_old <= masked_set;
            r_out_en  <= en_next;
            r_out_irq <= irq;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_old_masked_set = r_out_old;
    assign o_mi_enable      = r_out_en.mi;
    assign o_dsp_enable     = r_out_en.dsp;
    assign o_ai_enable      = r_out_en.ai;
    assign o_exi0_enable    = r_out_en.exi0;
    assign o_exi1_enable    = r_out_en.exi1;
    assign o_exi2_enable    = r_out_en.exi2;
    assign o_pi_enable      = r_out_en.pi;
    assign o_irq_found      = r_out_irq.found;
    assign o_irq_number     = r_out_irq.number;

endmodule

/* rtl/core/impd_checker.sv */
// Port-level assertions for the interrupt dispatch unit and their bind.
module impd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [14:0] o_pi_enable,
    input logic        o_irq_found,
    input logic [4:0]  o_irq_number
);

    // No result may leave the block right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // A stalled result stays presented
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // Fixed processor interface enables never clear
    a_pi_fixed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_pi_enable[7:4] == 4'hF)
        else $error("fixed processor interface enables cleared");

    // Without a chosen interrupt the number reads zero
    a_no_irq_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_irq_found |-> o_irq_number == 5'd0)
        else $error("interrupt number set without a dispatch hit");

    // Input side stalls only while a result is waiting downstream
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled with the result path free");

endmodule

bind interrupt_mask_and_priority_dispatch_unit impd_checker u_impd_checker (.*);
